// File: rtl/assert_macros.svh
// Assertion macros used by rotation_matrix_to_quaternion_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define R2Q_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("r2q assertion failed");
// Checks that a condition implies a consequence in the same cycle.
`define R2Q_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("r2q implication failed");
`else
`define R2Q_ASSERT(label, clk, rst_n, prop)
`define R2Q_ASSERT_IMPL(label, clk, rst_n, cond, cons)
`endif
`endif

// File: rtl/r2q_pkg.sv
// ----------------------------------------------------------------------------
// r2q_pkg
// Types and constants of the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
package r2q_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 14;
	localparam int THR_W      = 15;
	localparam int VEC_W      = 19;
	localparam int MAG_W      = 18;
	localparam int NM_W       = 20;
	localparam int NORM_TOP   = 19;
	localparam int SQ_W       = 40;
	localparam int SUM_W      = 42;
	localparam int RAD_W      = 64;
	localparam int ROOT_W     = 31;
	localparam int SQRT_CELLS = 31;
	localparam int DIV_CELLS  = 16;
	localparam int REM_W      = 47;
	localparam int QUO_W      = 16;
	localparam int LATENCY    = 53;

	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_X     = 2'd1;
	localparam logic [1:0] BR_Y     = 2'd2;
	localparam logic [1:0] BR_Z     = 2'd3;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] m00;
		logic signed [DATA_WIDTH-1:0] m01;
		logic signed [DATA_WIDTH-1:0] m02;
		logic signed [DATA_WIDTH-1:0] m10;
		logic signed [DATA_WIDTH-1:0] m11;
		logic signed [DATA_WIDTH-1:0] m12;
		logic signed [DATA_WIDTH-1:0] m20;
		logic signed [DATA_WIDTH-1:0] m21;
		logic signed [DATA_WIDTH-1:0] m22;
	} operand_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] qw;
		logic signed [DATA_WIDTH-1:0] qx;
		logic signed [DATA_WIDTH-1:0] qy;
		logic signed [DATA_WIDTH-1:0] qz;
		logic [1:0]                   branch_taken;
	} result_t;

	// Side information that travels with a transaction down the cell chains.
	typedef struct packed {
		logic [3:0][NM_W-1:0] nm;
		logic [3:0]           neg;
		logic [1:0]           br;
		logic                 zero;
	} carry_t;

endpackage

// File: rtl/r2q_front.sv
// ----------------------------------------------------------------------------
// r2q_front
// Branch selection, vector build, magnitude normalization and sum of squares.
// ----------------------------------------------------------------------------
module r2q_front import r2q_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  operand_t         operand,
	input  logic [THR_W-1:0] thr,
	output logic             valid_o,
	output carry_t           carry_o,
	output logic [SUM_W-1:0] nsum_o
);

	localparam logic signed [VEC_W-1:0] ONE = VEC_W'(1) << FRAC_BITS;

	logic signed [VEC_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
	logic signed [VEC_W-1:0] r0, rb;
	logic signed [VEC_W-1:0] v [4];
	logic [1:0]              br;

	logic                    valid_s1, valid_s2, valid_s3, valid_s4;
	logic [3:0][MAG_W-1:0]   mag_s1;
	logic [3:0]              neg_s1;
	logic [1:0]              br_s1;
	logic                    zero_s1;
	carry_t                  carry_s2, carry_s3, carry_s4;
	logic [3:0][SQ_W-1:0]    sq_s3;
	logic [SUM_W-1:0]        nsum_s4;

	logic [MAG_W-1:0]        ored;
	logic [4:0]              top;
	logic [4:0]              sh;

	always_comb begin
		a00 = VEC_W'(operand.m00);
		a01 = VEC_W'(operand.m01);
		a02 = VEC_W'(operand.m02);
		a10 = VEC_W'(operand.m10);
		a11 = VEC_W'(operand.m11);
		a12 = VEC_W'(operand.m12);
		a20 = VEC_W'(operand.m20);
		a21 = VEC_W'(operand.m21);
		a22 = VEC_W'(operand.m22);
		r0  = ONE + a00 + a11 + a22;
		priority if (r0 > $signed({4'b0, thr})) begin
			br = BR_TRACE;
			rb = r0;
			v[0] = r0;        v[1] = a21 - a12; v[2] = a02 - a20; v[3] = a10 - a01;
		end else if (a00 > a11 && a00 > a22) begin
			br = BR_X;
			rb = ONE + a00 - a11 - a22;
			v[0] = a21 - a12; v[1] = rb;        v[2] = a01 + a10; v[3] = a02 + a20;
		end else if (a11 > a22) begin
			br = BR_Y;
			rb = ONE + a11 - a00 - a22;
			v[0] = a02 - a20; v[1] = a01 + a10; v[2] = rb;        v[3] = a12 + a21;
		end else begin
			br = BR_Z;
			rb = ONE + a22 - a00 - a11;
			v[0] = a10 - a01; v[1] = a02 + a20; v[2] = a12 + a21; v[3] = rb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			neg_s1[i] <= v[i][VEC_W-1];
			mag_s1[i] <= v[i][VEC_W-1] ? MAG_W'(-v[i]) : MAG_W'(v[i]);
		end
		br_s1   <= br;
		zero_s1 <= (rb <= 0);
	end

	// The top set bit of the largest magnitude is the top set bit of their OR.
	always_comb begin
		ored = mag_s1[0] | mag_s1[1] | mag_s1[2] | mag_s1[3];
		top  = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (ored[i]) begin
				top = 5'(i);
			end
		end
		sh = 5'(NORM_TOP) - top;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			carry_s2.nm[i] <= NM_W'(mag_s1[i]) << sh;
		end
		carry_s2.neg  <= neg_s1;
		carry_s2.br   <= br_s1;
		carry_s2.zero <= zero_s1 || (ored == '0);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			sq_s3[i] <= SQ_W'(carry_s2.nm[i]) * SQ_W'(carry_s2.nm[i]);
		end
		carry_s3 <= carry_s2;
	end

	always_ff @(posedge clk) begin
		nsum_s4  <= SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]) + SUM_W'(sq_s3[3]);
		carry_s4 <= carry_s3;
	end

	assign valid_o = valid_s4;
	assign carry_o = carry_s4;
	assign nsum_o  = nsum_s4;

endmodule

// File: rtl/r2q_sqrt_cell.sv
// ----------------------------------------------------------------------------
// r2q_sqrt_cell
// One digit of a restoring integer square root; decides one root bit.
// ----------------------------------------------------------------------------
module r2q_sqrt_cell import r2q_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [4:0]        bit_idx,
	input  logic              valid_i,
	input  carry_t            carry_i,
	input  logic [RAD_W-1:0]  rem_i,
	input  logic [ROOT_W-1:0] root_i,
	output logic              valid_o,
	output carry_t            carry_o,
	output logic [RAD_W-1:0]  rem_o,
	output logic [ROOT_W-1:0] root_o
);

	logic [RAD_W-1:0] trial;
	logic             ge;

	// Raising the root by 2^k grows its square by root*2^(k+1) + 2^(2k).
	always_comb begin
		trial = (RAD_W'(root_i) << (bit_idx + 5'd1)) | (RAD_W'(1) << {bit_idx, 1'b0});
		ge    = rem_i >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		carry_o <= carry_i;
		rem_o   <= ge ? rem_i - trial : rem_i;
		root_o  <= ge ? root_i | (ROOT_W'(1) << bit_idx) : root_i;
	end

endmodule

// File: rtl/r2q_div_cell.sv
// ----------------------------------------------------------------------------
// r2q_div_cell
// One quotient bit of restoring division, for all four components at once.
// ----------------------------------------------------------------------------
module r2q_div_cell import r2q_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [3:0]            bit_idx,
	input  logic                  valid_i,
	input  carry_t                carry_i,
	input  logic [ROOT_W-1:0]     root_i,
	input  logic [3:0][REM_W-1:0] rem_i,
	input  logic [3:0][QUO_W-1:0] quo_i,
	output logic                  valid_o,
	output carry_t                carry_o,
	output logic [ROOT_W-1:0]     root_o,
	output logic [3:0][REM_W-1:0] rem_o,
	output logic [3:0][QUO_W-1:0] quo_o
);

	logic [REM_W-1:0] trial;

	assign trial = REM_W'(root_i) << bit_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		carry_o <= carry_i;
		root_o  <= root_i;
		for (int i = 0; i < 4; i++) begin
			if (rem_i[i] >= trial) begin
				rem_o[i] <= rem_i[i] - trial;
				quo_o[i] <= quo_i[i] | (QUO_W'(1) << bit_idx);
			end else begin
				rem_o[i] <= rem_i[i];
				quo_o[i] <= quo_i[i];
			end
		end
	end

endmodule

// File: rtl/rotation_matrix_to_quaternion_unit.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts a 3x3 rotation matrix in Q1.14 into a unit quaternion in Q1.14.
// ----------------------------------------------------------------------------
// The unit takes one matrix transaction in every clock cycle and never raises
// busy. Each result appears on the result ports, marked by done, exactly 53
// cycles after its start, and stays there for that one cycle only: the
// receiver must take it then, as nothing holds it back. The latency is set by
// four front stages, a chain of 31 square root cells (one root bit each), one
// dividend stage, a chain of 16 divider cells (one quotient bit each for all
// four components) and the output register. Results leave in input order.
//
// The trace formula is chosen when one plus the trace exceeds trace_threshold.
// Otherwise the strictly largest diagonal entry selects the branch, and the
// branch used is reported in branch_taken. The four unnormalized components
// are shifted so the largest has its top bit at bit 19, the root of the sum
// of squares is taken, and each component is divided by it with rounding and
// clamped to one. A matrix with a non-positive radicand yields all zeros.
// The threshold register may be written at any time through the cfg channel,
// which is always ready; it should change only while no transaction is in
// flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotation_matrix_to_quaternion_unit import r2q_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  operand_t         operand,
	output logic             done,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [THR_W-1:0] cfg_data
);

	localparam logic [QUO_W-1:0] LIM = QUO_W'(1) << FRAC_BITS;

	logic [THR_W-1:0] thr_q;

	logic             fe_valid;
	carry_t           fe_carry;
	logic [SUM_W-1:0] fe_nsum;

	// Square root chain wires: index 0 feeds the first cell.
	logic              sq_valid [SQRT_CELLS+1];
	carry_t            sq_carry [SQRT_CELLS+1];
	logic [RAD_W-1:0]  sq_rem   [SQRT_CELLS+1];
	logic [ROOT_W-1:0] sq_root  [SQRT_CELLS+1];

	logic                  dv_valid [DIV_CELLS+1];
	carry_t                dv_carry [DIV_CELLS+1];
	logic [ROOT_W-1:0]     dv_root  [DIV_CELLS+1];
	logic [3:0][REM_W-1:0] dv_rem   [DIV_CELLS+1];
	logic [3:0][QUO_W-1:0] dv_quo   [DIV_CELLS+1];

	logic                  done_q;
	result_t               result_q;
	logic [3:0][QUO_W-1:0] qc;
	logic [3:0][QUO_W-1:0] qs;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	r2q_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (start && !busy),
		.operand (operand),
		.thr     (thr_q),
		.valid_o (fe_valid),
		.carry_o (fe_carry),
		.nsum_o  (fe_nsum)
	);

	// The root is taken of the sum of squares scaled by 2^20.
	assign sq_valid[0] = fe_valid;
	assign sq_carry[0] = fe_carry;
	assign sq_rem[0]   = RAD_W'({fe_nsum, 20'b0});
	assign sq_root[0]  = '0;

	for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
		r2q_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bit_idx (5'(SQRT_CELLS - 1 - g)),
			.valid_i (sq_valid[g]),
			.carry_i (sq_carry[g]),
			.rem_i   (sq_rem[g]),
			.root_i  (sq_root[g]),
			.valid_o (sq_valid[g+1]),
			.carry_o (sq_carry[g+1]),
			.rem_o   (sq_rem[g+1]),
			.root_o  (sq_root[g+1])
		);
	end

	// Dividend stage: each magnitude scaled by 2^24 plus half the root rounds
	// the quotient to nearest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_valid[0] <= 1'b0;
		end else begin
			dv_valid[0] <= sq_valid[SQRT_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		dv_carry[0] <= sq_carry[SQRT_CELLS];
		dv_root[0]  <= sq_root[SQRT_CELLS];
		for (int i = 0; i < 4; i++) begin
			dv_rem[0][i] <= (REM_W'(sq_carry[SQRT_CELLS].nm[i]) << (FRAC_BITS + 10))
				+ REM_W'(sq_root[SQRT_CELLS] >> 1);
			dv_quo[0][i] <= '0;
		end
	end

	for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
		r2q_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bit_idx (4'(DIV_CELLS - 1 - g)),
			.valid_i (dv_valid[g]),
			.carry_i (dv_carry[g]),
			.root_i  (dv_root[g]),
			.rem_i   (dv_rem[g]),
			.quo_i   (dv_quo[g]),
			.valid_o (dv_valid[g+1]),
			.carry_o (dv_carry[g+1]),
			.root_o  (dv_root[g+1]),
			.rem_o   (dv_rem[g+1]),
			.quo_o   (dv_quo[g+1])
		);
	end

	// Clamp to one, restore the sign, and force zeros for a degenerate matrix.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qc[i] = (dv_quo[DIV_CELLS][i] > LIM) ? LIM : dv_quo[DIV_CELLS][i];
			if (dv_carry[DIV_CELLS].zero) begin
				qs[i] = '0;
			end else if (dv_carry[DIV_CELLS].neg[i]) begin
				qs[i] = -qc[i];
			end else begin
				qs[i] = qc[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid[DIV_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		result_q.qw           <= signed'(qs[0]);
		result_q.qx           <= signed'(qs[1]);
		result_q.qy           <= signed'(qs[2]);
		result_q.qz           <= signed'(qs[3]);
		result_q.branch_taken <= dv_carry[DIV_CELLS].br;
	end

	assign done   = done_q;
	assign result = result_q;

	`R2Q_ASSERT(a_fixed_latency, clk, arst_n, start && !busy |-> ##LATENCY done)
	`R2Q_ASSERT_IMPL(a_unit_range, clk, arst_n, done,
		result.qw >= -16'sd16384 && result.qw <= 16'sd16384 &&
		result.qx >= -16'sd16384 && result.qx <= 16'sd16384 &&
		result.qy >= -16'sd16384 && result.qy <= 16'sd16384 &&
		result.qz >= -16'sd16384 && result.qz <= 16'sd16384)
	`R2Q_ASSERT_IMPL(a_trace_w_nonneg, clk, arst_n,
		done && result.branch_taken == BR_TRACE, result.qw >= 16'sd0)

endmodule
